@@ hw/rtl/ocws_pkg.sv @@
package ocws_pkg;

  // Defaults and fixed sizes of the block.
  localparam int ANGLE_BITS_DEF = 16;
  localparam int WHEEL_COUNT    = 4;
  localparam int CORDIC_STEPS   = 16;
  localparam int CORDIC_W       = 34;
  localparam int CFG_INDEX_W    = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_GAIN   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATE_GAIN = 8'd1;

  // Gain compensation in Q1.30 and 57.2958 in Q16.
  localparam logic signed [CORDIC_W-1:0] CORDIC_K        = 34'sd652032874;
  localparam logic signed [23:0]         DEG_PER_RAD_Q16 = 24'sd3754938;

  // Command fields that travel beside the rotation chain.
  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] turn;
    logic               flip;
  } cmd_t;

  // Arc tangent of 2^-i as a fraction of a turn, 2^32 per full turn.
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input int step);
    logic signed [CORDIC_W-1:0] val;
    case (step)
      0:       val = 34'sd536870912;
      1:       val = 34'sd316933406;
      2:       val = 34'sd167458907;
      3:       val = 34'sd85004756;
      4:       val = 34'sd42667331;
      5:       val = 34'sd21354465;
      6:       val = 34'sd10679838;
      7:       val = 34'sd5340245;
      8:       val = 34'sd2670163;
      9:       val = 34'sd1335087;
      10:      val = 34'sd667544;
      11:      val = 34'sd333772;
      12:      val = 34'sd166886;
      13:      val = 34'sd83443;
      14:      val = 34'sd41722;
      15:      val = 34'sd20861;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/ocws_cordic_cell.sv @@
module ocws_cordic_cell
  import ocws_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid_in,
  input  logic signed [CORDIC_W-1:0] x_in,
  input  logic signed [CORDIC_W-1:0] y_in,
  input  logic signed [CORDIC_W-1:0] z_in,
  input  cmd_t                       cmd_in,
  output logic                       valid_out,
  output logic signed [CORDIC_W-1:0] x_out,
  output logic signed [CORDIC_W-1:0] y_out,
  output logic signed [CORDIC_W-1:0] z_out,
  output cmd_t                       cmd_out
);

  localparam logic signed [CORDIC_W-1:0] ATAN = atan_turn(STEP);

  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;

  // Floor shifts of the partner coordinate.
  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  // One micro-rotation toward zero residual angle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in >= 0) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN;
      end
      cmd_out <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

endmodule

@@ hw/rtl/ocws_mix.sv @@
module ocws_mix
  import ocws_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid_in,
  input  logic signed [CORDIC_W-1:0] x_in,
  input  logic signed [CORDIC_W-1:0] y_in,
  input  cmd_t                       cmd_in,
  input  logic [15:0]                move_gain,
  input  logic [15:0]                rotate_gain,
  output logic                       valid_out,
  output logic signed [23:0]         wheel [WHEEL_COUNT]
);

  localparam int STAGES = 6;

  logic [STAGES-1:0] valid;

  // Stage 1: undo the half-turn fold, form rounded c-s and s+c, rotation product.
  logic signed [34:0] c_val;
  logic signed [34:0] s_val;
  logic signed [35:0] d_rnd;
  logic signed [35:0] e_rnd;
  logic signed [17:0] d15;
  logic signed [17:0] e15;
  logic signed [32:0] rot;
  logic signed [15:0] speed1;

  assign c_val = cmd_in.flip ? -35'(x_in) : 35'(x_in);
  assign s_val = cmd_in.flip ? -35'(y_in) : 35'(y_in);
  assign d_rnd = 36'(c_val) - 36'(s_val) + 36'sd16384;
  assign e_rnd = 36'(s_val) + 36'(c_val) + 36'sd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      d15    <= d_rnd[32:15];
      e15    <= e_rnd[32:15];
      rot    <= 33'(cmd_in.turn) * 33'($signed({1'b0, rotate_gain}));
      speed1 <= cmd_in.speed;
    end
  end

  // Stage 2: speed times the direction terms.
  logic signed [33:0] vd;
  logic signed [33:0] ve;
  logic signed [32:0] rot2;

  always_ff @(posedge clk) begin
    if (en) begin
      vd   <= 34'(speed1) * 34'(d15);
      ve   <= 34'(speed1) * 34'(e15);
      rot2 <= rot;
    end
  end

  // Stage 3: apply the move gain, bring rotation to the same Q35 scale.
  logic signed [50:0] xg;
  logic signed [50:0] yg;
  logic signed [47:0] rot35;

  always_ff @(posedge clk) begin
    if (en) begin
      xg    <= 51'(vd) * 51'($signed({1'b0, move_gain}));
      yg    <= 51'(ve) * 51'($signed({1'b0, move_gain}));
      rot35 <= {rot2, 15'b0};
    end
  end

  // Stage 4: wheel sums, rounded to Q20.
  logic signed [51:0] wsum [WHEEL_COUNT];
  logic signed [34:0] w20  [WHEEL_COUNT];

  always_comb begin
    wsum[0] = 52'(yg) + 52'(rot35) + 52'sd16384;
    wsum[1] = 52'(rot35) - 52'(xg) + 52'sd16384;
    wsum[2] = 52'(rot35) - 52'(yg) + 52'sd16384;
    wsum[3] = 52'(xg) + 52'(rot35) + 52'sd16384;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        w20[k] <= wsum[k][49:15];
      end
    end
  end

  // Stage 5: rad/s to 1/16 deg/s scale product.
  logic signed [59:0] prod [WHEEL_COUNT];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        prod[k] <= 60'(w20[k]) * 60'(DEG_PER_RAD_Q16);
      end
    end
  end

  // Stage 6: negate, round and saturate into the output register.
  logic signed [60:0] neg_rnd [WHEEL_COUNT];
  logic signed [28:0] o_full  [WHEEL_COUNT];

  always_comb begin
    for (int k = 0; k < WHEEL_COUNT; k++) begin
      neg_rnd[k] = 61'sd2147483648 - 61'(prod[k]);
      o_full[k]  = neg_rnd[k][60:32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        if (o_full[k] > 29'sd8388607) begin
          wheel[k] <= 24'sh7FFFFF;
        end else if (o_full[k] < -29'sd8388608) begin
          wheel[k] <= 24'sh800000;
        end else begin
          wheel[k] <= o_full[k][23:0];
        end
      end
    end
  end

  // Valid bits follow the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[STAGES-2:0], valid_in};
    end
  end

  assign valid_out = valid[STAGES-1];

endmodule

@@ hw/rtl/omni_chassis_wheel_speeds_unit.sv @@
// Pipeline: 16 rotation cells, then 6 arithmetic stages ending in the output
// register. Throughput: one command per cycle; the whole pipeline advances
// together and holds only while a finished result waits on a low
// m_axis_tready.
// Reset (rst, synchronous, active high) clears all valid bits and both gains;
// no input or configuration beat is taken while it is high.
module omni_chassis_wheel_speeds_unit
  import ocws_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] linear_speed, [31:16] heading, [47:32] turn_rate
  input  logic [47:0]            s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [23:0] wheel_right_front, [47:24] wheel_left_front,
  // [71:48] wheel_left_rear, [95:72] wheel_right_rear
  output logic [95:0]            m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  logic        en;
  logic [15:0] move_gain;
  logic [15:0] rotate_gain;

  // Configuration registers; writes are taken whenever reset is low.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_gain   <= '0;
      rotate_gain <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MOVE_GAIN) begin
        move_gain <= cfg_data;
      end else if (cfg_index == REG_ROTATE_GAIN) begin
        rotate_gain <= cfg_data;
      end
    end
  end

  // Pipeline advances unless the output register holds an untaken beat.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  // Heading as a 32-bit turn, folded into [-90, 90) degrees.
  logic [31:0] angle;
  logic        flip;
  logic [31:0] angle_fold;
  cmd_t        cmd_first;

  assign angle      = (32'(s_axis_tdata[31:16]) & ANGLE_MASK) << (32 - ANGLE_BITS);
  assign flip       = angle[31] ^ angle[30];
  assign angle_fold = {angle[31] ^ flip, angle[30:0]};

  always_comb begin
    cmd_first.speed = s_axis_tdata[15:0];
    cmd_first.turn  = s_axis_tdata[47:32];
    cmd_first.flip  = flip;
  end

  // Chain of rotation cells.
  logic [CORDIC_STEPS:0]      chain_valid;
  logic signed [CORDIC_W-1:0] chain_x   [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] chain_y   [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] chain_z   [CORDIC_STEPS+1];
  cmd_t                       chain_cmd [CORDIC_STEPS+1];

  assign chain_valid[0] = s_axis_tvalid;
  assign chain_x[0]     = CORDIC_K;
  assign chain_y[0]     = '0;
  assign chain_z[0]     = CORDIC_W'($signed(angle_fold));
  assign chain_cmd[0]   = cmd_first;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    ocws_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (chain_valid[i]),
      .x_in      (chain_x[i]),
      .y_in      (chain_y[i]),
      .z_in      (chain_z[i]),
      .cmd_in    (chain_cmd[i]),
      .valid_out (chain_valid[i+1]),
      .x_out     (chain_x[i+1]),
      .y_out     (chain_y[i+1]),
      .z_out     (chain_z[i+1]),
      .cmd_out   (chain_cmd[i+1])
    );
  end

  // Gains, wheel mixing and unit conversion.
  logic signed [23:0] wheel [WHEEL_COUNT];

  ocws_mix u_mix (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .valid_in    (chain_valid[CORDIC_STEPS]),
    .x_in        (chain_x[CORDIC_STEPS]),
    .y_in        (chain_y[CORDIC_STEPS]),
    .cmd_in      (chain_cmd[CORDIC_STEPS]),
    .move_gain   (move_gain),
    .rotate_gain (rotate_gain),
    .valid_out   (m_axis_tvalid),
    .wheel       (wheel)
  );

  assign m_axis_tdata = {wheel[3], wheel[2], wheel[1], wheel[0]};

endmodule

@@ bench/omni_chassis_wheel_speeds_unit_test.sv @@
`timescale 1ns / 1ps

module omni_chassis_wheel_speeds_unit_test;
  import ocws_pkg::*;

  // One output beat viewed as four wheel speeds; index 0 is the right-front wheel.
  typedef logic [WHEEL_COUNT-1:0][23:0] wheel_set_t;

  // Sender and receiver pacing modes.
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One row of the directed command table, with the gains it runs under.
  typedef struct packed {
    logic [15:0]        move_gain;
    logic [15:0]        rotate_gain;
    logic signed [15:0] speed;
    logic [15:0]        heading;
    logic signed [15:0] turn;
    logic               known;
    wheel_set_t         known_wheels;
  } command_row_t;

  localparam int ROW_COUNT    = 24;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 250;
  localparam int MODE_STRETCH = 40;

  // Rotation constants: gain compensation in Q1.30, arc tangents in 2^32 per turn.
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
  localparam longint TURN_ATAN [CORDIC_STEPS] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
    64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
    64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
    64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861
  };
  localparam longint DEG_PER_RAD_SCALED = 64'sd3754938;
  localparam longint HALF_Q15           = 64'sd16384;
  localparam longint HALF_Q32           = 64'sd2147483648;
  localparam longint WHEEL_MAX          = 64'sd8388607;
  localparam longint WHEEL_MIN          = -64'sd8388608;

  // Directed commands: zero gains after reset, field extremes at full gains,
  // quadrant edges of the heading at moderate gains, then one gain at a time.
  localparam command_row_t COMMAND_ROWS [ROW_COUNT] = '{
    '{16'h0000, 16'h0000, 16'sh7FFF, 16'h0000, 16'sh7FFF, 1'b1, '0},
    '{16'h0000, 16'h0000, 16'sh8000, 16'hFFFF, 16'sh8000, 1'b1, '0},
    '{16'h0000, 16'h0000, 16'sh1234, 16'h4000, 16'shC321, 1'b1, '0},
    '{16'hFFFF, 16'hFFFF, 16'sh0000, 16'h5555, 16'sh0000, 1'b1, '0},
    '{16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'h0000, 16'sh0000, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'sh8000, 16'h0000, 16'sh0000, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'sh0000, 16'h0000, 16'sh7FFF, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'sh0000, 16'h0000, 16'sh8000, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'h4000, 16'sh7FFF, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'sh8000, 16'h8000, 16'sh8000, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'hC000, 16'sh8000, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'sh8000, 16'hFFFF, 16'sh7FFF, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'h2000, 16'sh0001, 1'b0, '0},
    '{16'h0180, 16'h0040, 16'sh1000, 16'h0001, 16'sh0400, 1'b0, '0},
    '{16'h0180, 16'h0040, 16'sh1000, 16'h3FFF, 16'sh0400, 1'b0, '0},
    '{16'h0180, 16'h0040, 16'sh1000, 16'h4000, 16'shFC00, 1'b0, '0},
    '{16'h0180, 16'h0040, 16'sh1000, 16'h4001, 16'sh0400, 1'b0, '0},
    '{16'h0180, 16'h0040, 16'shF000, 16'h7FFF, 16'sh0400, 1'b0, '0},
    '{16'h0180, 16'h0040, 16'shF000, 16'h8000, 16'sh0000, 1'b0, '0},
    '{16'h0180, 16'h0040, 16'sh1000, 16'hBFFF, 16'shFC00, 1'b0, '0},
    '{16'h0180, 16'h0040, 16'sh1000, 16'hC000, 16'sh0400, 1'b0, '0},
    '{16'h0180, 16'h0040, 16'sh1000, 16'hC001, 16'sh0400, 1'b0, '0},
    '{16'hFFFF, 16'h0000, 16'sh7FFF, 16'h6000, 16'sh7FFF, 1'b0, '0},
    '{16'h0000, 16'hFFFF, 16'sh7FFF, 16'h6000, 16'sh8000, 1'b0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [47:0]            s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [95:0]            m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  // Gains as the block should hold them, and the wheel sets still in flight.
  logic [15:0] move_gain_q8 = '0;
  logic [15:0] rotate_gain_q8 = '0;
  wheel_set_t  wheels_due [$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  omni_chassis_wheel_speeds_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Rounds a Q35 rad/s sum to Q20, converts it to negated 1/16 deg/s and saturates.
  function automatic logic [23:0] wheel_units(input longint w35);
    longint w20;
    longint deg16;
    w20 = (w35 + HALF_Q15) >>> 15;
    deg16 = (-w20 * DEG_PER_RAD_SCALED + HALF_Q32) >>> 32;
    if (deg16 > WHEEL_MAX) deg16 = WHEEL_MAX;
    if (deg16 < WHEEL_MIN) deg16 = WHEEL_MIN;
    return deg16[23:0];
  endfunction

  // Inverse kinematics of one chassis command under the given gains.
  function automatic wheel_set_t predict_wheels(input logic signed [15:0] speed,
                                                input logic [15:0] heading,
                                                input logic signed [15:0] turn,
                                                input logic [15:0] move_gain,
                                                input logic [15:0] rotate_gain);
    logic [31:0] turn32;
    logic [31:0] biased;
    logic        flip;
    longint      x, y, z, dx, dy;
    longint      cos30, sin30, diff15, sum15;
    longint      v, w, mg, rg, move_x, move_y, rot;
    longint      w35 [WHEEL_COUNT];
    wheel_set_t  wheels;
    turn32 = 32'(heading) << (32 - ANGLE_BITS_DEF);
    // The back half circle is folded onto the front one and the result negated.
    biased = turn32 + 32'h4000_0000;
    flip = biased[31];
    if (flip) turn32 = turn32 - 32'h8000_0000;
    x = CORDIC_GAIN_Q30;
    y = 0;
    z = longint'($signed(turn32));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - TURN_ATAN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + TURN_ATAN[i];
      end
    end
    cos30 = flip ? -x : x;
    sin30 = flip ? -y : y;
    diff15 = (cos30 - sin30 + HALF_Q15) >>> 15;
    sum15 = (sin30 + cos30 + HALF_Q15) >>> 15;
    v = speed;
    w = turn;
    mg = move_gain;
    rg = rotate_gain;
    move_x = v * diff15 * mg;
    move_y = v * sum15 * mg;
    rot = w * rg * 64'sd32768;
    w35[0] = move_y + rot;
    w35[1] = -move_x + rot;
    w35[2] = -move_y + rot;
    w35[3] = move_x + rot;
    for (int k = 0; k < WHEEL_COUNT; k++) wheels[k] = wheel_units(w35[k]);
    return wheels;
  endfunction

  // Random signed Q4.12 value, weighted toward extremes and small magnitudes.
  function automatic logic signed [15:0] random_q12();
    logic signed [15:0] val;
    case ($urandom_range(7))
      0: val = 16'sh7FFF;
      1: val = 16'sh8000;
      2: val = 16'sh0000;
      3: val = 16'($urandom_range(8191)) - 16'sd4096;
      default: val = 16'($urandom);
    endcase
    return val;
  endfunction

  // Random heading, partly placed right around a quarter-turn boundary.
  function automatic logic [15:0] random_heading();
    logic [15:0] val;
    if ($urandom_range(3) == 0)
      val = 16'($urandom_range(3)) * 16'h4000 + 16'($urandom_range(2)) - 16'd1;
    else
      val = 16'($urandom);
    return val;
  endfunction

  task automatic set_idle_mode(input idle_mode_t mode);
    sender_idle_pct = (mode == IDLE_SENDER) ? 80 : (mode == IDLE_BOTH) ? 31 : 0;
    receiver_stall_pct = (mode == IDLE_RECEIVER) ? 80 : (mode == IDLE_BOTH) ? 31 : 0;
  endtask

  // Offers one command beat and records what its wheels should read.
  task automatic send_command(input logic signed [15:0] speed, input logic [15:0] heading,
                              input logic signed [15:0] turn, input logic known,
                              input wheel_set_t known_wheels);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {turn, heading, speed};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (known)
      wheels_due.push_back(known_wheels);
    else
      wheels_due.push_back(predict_wheels(speed, heading, turn, move_gain_q8, rotate_gain_q8));
  endtask

  // Stops sending and waits for every outstanding wheel set.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (wheels_due.size() != 0) @(posedge clk);
  endtask

  // One register beat; cfg_valid is lowered by the caller after the last one.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == REG_MOVE_GAIN)
      move_gain_q8 = data;
    else if (index == REG_ROTATE_GAIN)
      rotate_gain_q8 = data;
  endtask

  // Loads both gains while idle, after a write to an unused index that must be ignored.
  task automatic set_gains(input logic [15:0] move_gain, input logic [15:0] rotate_gain);
    logic [CFG_INDEX_W-1:0] unused_index;
    unused_index = CFG_INDEX_W'($urandom_range(2, (1 << CFG_INDEX_W) - 1));
    wait_idle();
    write_register(unused_index, 16'($urandom));
    write_register(REG_MOVE_GAIN, move_gain);
    write_register(REG_ROTATE_GAIN, rotate_gain);
    cfg_valid <= 1'b0;
  endtask

  // Result side: compare each accepted beat with the oldest wheel set, then pace tready.
  always @(posedge clk) begin : check_wheels
    wheel_set_t want;
    wheel_set_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (wheels_due.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected output beat %h", got);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = wheels_due.pop_front();
        for (int k = 0; k < WHEEL_COUNT; k++) begin
          if (got[k] !== want[k]) begin
            if (mismatch_count < 10)
              $display("wheel %0d mismatch: expected %h, got %h", k, want[k], got[k]);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_commands
    command_row_t row;
    logic [15:0]  phase_move;
    logic [15:0]  phase_rotate;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; the first rows run on the gains left by reset.
    set_idle_mode(IDLE_NONE);
    for (int r = 0; r < ROW_COUNT; r++) begin
      row = COMMAND_ROWS[r];
      if (row.move_gain != move_gain_q8 || row.rotate_gain != rotate_gain_q8)
        set_gains(row.move_gain, row.rotate_gain);
      send_command(row.speed, row.heading, row.turn, row.known, row.known_wheels);
    end

    // Random commands under extreme, random and typical gain settings.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin phase_move = 16'h0000; phase_rotate = 16'h0000; end
        1: begin phase_move = 16'hFFFF; phase_rotate = 16'hFFFF; end
        2: begin phase_move = 16'h0000; phase_rotate = 16'hFFFF; end
        3: begin phase_move = 16'hFFFF; phase_rotate = 16'h0000; end
        4: begin phase_move = 16'($urandom); phase_rotate = 16'($urandom); end
        default: begin
          phase_move = 16'($urandom_range(16'h0800, 16'h0080));
          phase_rotate = 16'($urandom_range(16'h0400, 16'h0010));
        end
      endcase
      set_gains(phase_move, phase_rotate);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        set_idle_mode(idle_mode_t'((n / MODE_STRETCH) % 4));
        send_command(random_q12(), random_heading(), random_q12(), 1'b0, '0);
      end
    end

    // Drain, then give the pipeline time to show any stray beat.
    wait_idle();
    set_idle_mode(IDLE_NONE);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && wheels_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ocws_pkg.sv
hw/rtl/ocws_cordic_cell.sv
hw/rtl/ocws_mix.sv
hw/rtl/omni_chassis_wheel_speeds_unit.sv
bench/omni_chassis_wheel_speeds_unit_test.sv
